// ----- rtl/gnst_pkg.sv -----
`default_nettype none

package gnst_pkg;

  localparam int CELL_W = 4;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int GEN_W  = 10;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 7;
  localparam int SUM_W  = 7;
  localparam int K_W    = 4;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [0:0] REG_GRID_SIDE       = 1'b0;
  localparam logic [0:0] REG_DEATH_THRESHOLD = 1'b1;

  localparam logic [CELL_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [K_W-1:0] K_CENTER = 4'd4;
  localparam logic [K_W-1:0] K_LAST   = 4'd9;

  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  typedef struct packed {
    logic [GEN_W-1:0]  generations;
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [MODE_W-1:0] mode;
  } item_t;

  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
  } nb_off_t;

  typedef struct packed {
    logic en;
    logic first;
    logic center;
    logic add;
  } sum_ctl_t;

  function automatic nb_off_t nb_off(input logic [K_W-1:0] k);
    nb_off_t off;
    off = '{dr: OFF_ZERO, dc: OFF_ZERO};
    case (k)
      4'd0: off = '{dr: OFF_NEG,  dc: OFF_NEG};
      4'd1: off = '{dr: OFF_NEG,  dc: OFF_ZERO};
      4'd2: off = '{dr: OFF_NEG,  dc: OFF_POS};
      4'd3: off = '{dr: OFF_ZERO, dc: OFF_NEG};
      4'd5: off = '{dr: OFF_ZERO, dc: OFF_POS};
      4'd6: off = '{dr: OFF_POS,  dc: OFF_NEG};
      4'd7: off = '{dr: OFF_POS,  dc: OFF_ZERO};
      4'd8: off = '{dr: OFF_POS,  dc: OFF_POS};
      default: off = '{dr: OFF_ZERO, dc: OFF_ZERO};
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/grid_neighbor_sum_threshold_step_unit.sv -----
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata: item word (mode, row, col, cell_value, generations)
// m_*      out        m_tvalid/m_tready  m_tdata: result word (read_value)
// cfg_*    in         cfg_wr_en          cfg_index, cfg_data: register write
//
// A write item is answered from the idle state; a read item passes through the memory read state.
// A step item sweeps all MAX_SIDE by MAX_SIDE cells once per generation: the single
// cell memory read port feeds one neighbor a cycle into the shared sum unit.
// Reset is synchronous; the cell memory is not cleared and holds unknowns until written.
// The output register holds a result under m_tready low; no new item is taken meanwhile.
module grid_neighbor_sum_threshold_step_unit
  import gnst_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // [1:0] mode, [7:2] row, [13:8] col, [17:14] cell_value, [27:18] generations
  input  wire logic [31:0]      s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [3:0] read_value
  output logic      [7:0]       m_tdata,
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  logic [CFG_W-1:0]  grid_side;
  logic [CFG_W-1:0]  death_threshold;
  logic [SIDE_W-1:0] side;
  logic [CMP_W-1:0]  side_ext;
  item_t             item;
  logic              start;
  logic              core_busy;
  logic              core_done;
  logic [CELL_W-1:0] core_value;
  logic [CELL_W-1:0] out_value;

  always_comb begin
    side_ext = CMP_W'(grid_side);
    if (grid_side == '0) begin
      side = SIDE_W'(1);
    end else if (side_ext > CMP_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = side_ext[SIDE_W-1:0];
    end
    item     = item_t'(s_tdata[$bits(item_t)-1:0]);
    s_tready = !core_busy && (!m_tvalid || m_tready);
    start    = s_tvalid && s_tready;
    m_tdata  = {4'b0000, out_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side       <= 7'd64;
      death_threshold <= 7'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_SIDE:       grid_side       <= cfg_data;
        REG_DEATH_THRESHOLD: death_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  gnst_core #(
    .MAX_SIDE (MAX_SIDE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .side       (side),
    .threshold  (death_threshold),
    .busy       (core_busy),
    .done       (core_done),
    .read_value (core_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      out_value <= core_value;
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst) core_done |-> !m_tvalid)
    else $error("result arrived while output register full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new word taken before previous item finished");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

// ----- rtl/gnst_sum_unit.sv -----
`default_nettype none

module gnst_sum_unit
  import gnst_pkg::*;
(
  input  wire logic              clk,
  input  wire sum_ctl_t          ctl,
  input  wire logic [CELL_W-1:0] data,
  input  wire logic [CFG_W-1:0]  threshold,
  output logic      [CELL_W-1:0] cell_next
);

  logic [SUM_W-1:0]  sum;
  logic [CELL_W-1:0] center;
  logic [SUM_W-1:0]  acc_in;
  logic [SUM_W-1:0]  addend;
  logic [SUM_W-1:0]  total;

  always_comb begin
    acc_in    = ctl.first ? '0 : sum;
    addend    = ctl.add ? SUM_W'(data) : '0;
    total     = acc_in + addend;
    cell_next = (total > SUM_W'(threshold)) ? '0 : center;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sum <= total;
      if (ctl.center) begin
        center <= data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gnst_core.sv -----
`default_nettype none

module gnst_core
  import gnst_pkg::*;
#(
  parameter  int MAX_SIDE = 64,
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire item_t             item,
  input  wire logic [SIDE_W-1:0] side,
  input  wire logic [CFG_W-1:0]  threshold,
  output logic                   busy,
  output logic                   done,
  output logic      [CELL_W-1:0] read_value
);

  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int CW        = IDX_W + 1;
  localparam int PW        = (IDX_W > ROW_W) ? IDX_W : ROW_W;
  localparam int ADDR_W    = 1 + 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SIDE - 1);

  logic [CELL_W-1:0] mem [MEM_DEPTH];

  logic [1:0]        state;
  logic              bank;
  logic [GEN_W-1:0]  gen_cnt;
  logic [IDX_W-1:0]  r;
  logic [IDX_W-1:0]  c;
  logic [K_W-1:0]    k;
  logic              inside_q;
  logic              mask_q;
  logic [CELL_W-1:0] rd_data;

  logic [PW-1:0]     row_p;
  logic [PW-1:0]     col_p;
  logic              inside_item;
  nb_off_t           off;
  logic [CW-1:0]     nr;
  logic [CW-1:0]     nc;
  logic              nr_ok;
  logic              nc_ok;
  logic              inside_cell;
  logic              nb_mask;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [CELL_W-1:0] sat_value;
  logic [CELL_W-1:0] cell_next;
  sum_ctl_t          ctl;

  always_comb begin
    row_p       = PW'(item.row);
    col_p       = PW'(item.col);
    inside_item = ({1'b0, row_p} < (PW + 1)'(side)) && ({1'b0, col_p} < (PW + 1)'(side));
    sat_value   = (item.cell_value > DIGIT_MAX) ? DIGIT_MAX : item.cell_value;

    off = nb_off(k);
    nr  = {1'b0, r};
    nc  = {1'b0, c};
    case (off.dr)
      OFF_NEG: nr = {1'b0, r} - CW'(1);
      OFF_POS: nr = {1'b0, r} + CW'(1);
      default: nr = {1'b0, r};
    endcase
    case (off.dc)
      OFF_NEG: nc = {1'b0, c} - CW'(1);
      OFF_POS: nc = {1'b0, c} + CW'(1);
      default: nc = {1'b0, c};
    endcase
    nr_ok       = !(off.dr == OFF_NEG && r == '0) && (nr < CW'(side));
    nc_ok       = !(off.dc == OFF_NEG && c == '0) && (nc < CW'(side));
    inside_cell = ({1'b0, r} < CW'(side)) && ({1'b0, c} < CW'(side));
    nb_mask     = inside_cell && nr_ok && nc_ok && (k != K_CENTER);

    if (state == S_GEN) begin
      rd_addr = {bank, nr[IDX_W-1:0], nc[IDX_W-1:0]};
    end else begin
      rd_addr = {bank, row_p[IDX_W-1:0], col_p[IDX_W-1:0]};
    end

    wr_en   = 1'b0;
    wr_addr = {bank, row_p[IDX_W-1:0], col_p[IDX_W-1:0]};
    wr_data = sat_value;
    if (state == S_GEN && k == K_LAST) begin
      wr_en   = 1'b1;
      wr_addr = {~bank, r, c};
      wr_data = cell_next;
    end else if (state == S_IDLE && start && item.mode == MODE_WRITE && inside_item) begin
      wr_en = 1'b1;
    end

    ctl.en     = (state == S_GEN) && (k != '0);
    ctl.first  = (k == K_W'(1));
    ctl.center = (k == K_CENTER + K_W'(1));
    ctl.add    = mask_q;

    busy = (state != S_IDLE) || done;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  gnst_sum_unit u_sum (
    .clk       (clk),
    .ctl       (ctl),
    .data      (rd_data),
    .threshold (threshold),
    .cell_next (cell_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      bank     <= 1'b0;
      done     <= 1'b0;
      gen_cnt  <= '0;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      inside_q <= 1'b0;
      mask_q   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (item.mode)
              MODE_READ: begin
                state    <= S_READ;
                inside_q <= inside_item;
              end
              MODE_STEP: begin
                if (item.generations == '0) begin
                  done       <= 1'b1;
                  read_value <= '0;
                end else begin
                  state   <= S_GEN;
                  gen_cnt <= item.generations;
                  r       <= '0;
                  c       <= '0;
                  k       <= '0;
                end
              end
              default: begin
                done       <= 1'b1;
                read_value <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          done       <= 1'b1;
          read_value <= inside_q ? rd_data : '0;
          state      <= S_IDLE;
        end
        S_GEN: begin
          mask_q <= nb_mask;
          if (k == K_LAST) begin
            k <= '0;
            if (c == IDX_LAST) begin
              c <= '0;
              if (r == IDX_LAST) begin
                r       <= '0;
                bank    <= ~bank;
                gen_cnt <= gen_cnt - GEN_W'(1);
                if (gen_cnt == GEN_W'(1)) begin
                  state      <= S_IDLE;
                  done       <= 1'b1;
                  read_value <= '0;
                end
              end else begin
                r <= r + IDX_W'(1);
              end
            end else begin
              c <= c + IDX_W'(1);
            end
          end else begin
            k <= k + K_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe held longer than one cycle");

  a_gen_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN) |-> (gen_cnt != '0) && (k <= K_LAST))
    else $error("generation sweep running with empty count or bad step");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE) && !done)
    else $error("item started while core busy");

endmodule

`default_nettype wire
